// ===== rtl/core/tmi_pkg.sv =====
// shared types, constants and control program of the tape machine interpreter
`timescale 1ns / 1ps

package tmi_pkg;

    // default sizes of the program store, tape and loop stack
    localparam int TMI_PROG_DEPTH = 1024;
    localparam int TMI_TAPE_DEPTH = 1024;
    localparam int TMI_LOOP_DEPTH = 16;

    // fixed field widths
    localparam int DATA_W = 8;
    localparam int OPC_W  = 3;
    localparam int ERR_W  = 3;
    localparam int PCO_W  = 11;

    // instruction set
    typedef enum logic [OPC_W-1:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } t_op;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_PTR_LOW   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_PTR_HIGH  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_UNMATCHED = 3'd4;
    localparam logic [ERR_W-1:0] ERR_PROG_FULL = 3'd5;

    // item mode
    localparam logic MODE_LOAD = 1'b0;

    // micro-program layout
    localparam int UPC_W = 1;

    localparam logic [UPC_W-1:0] UA_FETCH = 1'd0;
    localparam logic [UPC_W-1:0] UA_EXEC  = 1'd1;

    // jump conditions
    typedef enum logic [1:0] {
        COND_NEVER    = 2'd0,
        COND_NO_BEAT  = 2'd1,
        COND_OUT_BUSY = 2'd2,
        COND_ALWAYS   = 2'd3
    } t_cond;

    // one control word
    typedef struct packed {
        logic              accept;
        logic              exec;
        t_cond             cond;
        logic [UPC_W-1:0]  target;
        logic [UPC_W-1:0]  next;
    } t_uop;

    // status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } t_stat;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        logic accept;
        logic fire;
    } t_ctrl;

    // one result item
    typedef struct packed {
        logic              out_valid;
        logic [DATA_W-1:0] out_byte;
        logic              took_input;
        logic              halted;
        logic [ERR_W-1:0]  error_code;
        logic [PCO_W-1:0]  program_counter;
    } t_res;

    // control program: wait for a beat with reads issued, then execute once the
    // output register has room
    function automatic t_uop uop_rom(input logic [UPC_W-1:0] addr);
        t_uop u;
        begin
            unique case (addr)
                UA_FETCH: begin
                    u = '{accept: 1'b1, exec: 1'b0, cond: COND_NO_BEAT,
                          target: UA_FETCH, next: UA_EXEC};
                end
                UA_EXEC: begin
                    u = '{accept: 1'b0, exec: 1'b1, cond: COND_OUT_BUSY,
                          target: UA_EXEC, next: UA_FETCH};
                end
            endcase
            return u;
        end
    endfunction

endpackage

// ===== rtl/core/tmi_useq.sv =====
// micro-sequencer: step counter over the control program with conditional jumps
`timescale 1ns / 1ps

module tmi_useq
    import tmi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uop             uop;
    logic             cond_hit;

    // decode the current control word
    always_comb begin
        uop = uop_rom(r_upc);
        unique case (uop.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_NO_BEAT:  cond_hit = !i_stat.in_valid;
            COND_OUT_BUSY: cond_hit = i_stat.out_busy;
            COND_ALWAYS:   cond_hit = 1'b1;
        endcase
        n_upc         = cond_hit ? uop.target : uop.next;
        o_ctrl.accept = uop.accept;
        o_ctrl.fire   = uop.exec && !cond_hit;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== rtl/core/tmi_datapath.sv =====
// datapath: program, tape and loop stack memories and the instruction execute logic
`timescale 1ns / 1ps

module tmi_datapath
    import tmi_pkg::*;
#(
    parameter int PROG_DEPTH = TMI_PROG_DEPTH,
    parameter int TAPE_DEPTH = TMI_TAPE_DEPTH,
    parameter int LOOP_DEPTH = TMI_LOOP_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic              i_mode,
    input  logic [OPC_W-1:0]  i_opcode,
    input  logic [DATA_W-1:0] i_input_byte,
    output t_res              o_res
);

    localparam int PCW = $clog2(PROG_DEPTH + 1);
    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int TPW = $clog2(TAPE_DEPTH);
    localparam int TFW = $clog2(TAPE_DEPTH + 1);
    localparam int SCW = $clog2(LOOP_DEPTH + 1);
    localparam int SAW = $clog2(LOOP_DEPTH);

    // memories
    t_op               mem_prog [PROG_DEPTH];
    logic [DATA_W-1:0] mem_tape [TAPE_DEPTH];
    logic [PAW-1:0]    mem_stk  [LOOP_DEPTH];

    // captured beat
    logic              r_mode;
    t_op               r_opc;
    logic [DATA_W-1:0] r_inb;

    // registered read data
    t_op               r_prog_rd;
    logic [DATA_W-1:0] r_tape_rd;
    logic [PAW-1:0]    r_stk_rd;

    // machine state
    logic [PCW-1:0]   r_len,  n_len;
    logic [PCW-1:0]   r_pc,   n_pc;
    logic [TPW-1:0]   r_ptr,  n_ptr;
    logic [TFW-1:0]   r_fill, n_fill;
    logic [SCW-1:0]   r_sc,   n_sc;
    logic [PCW-1:0]   r_skip, n_skip;
    logic [ERR_W-1:0] r_err,  n_err;

    // write controls
    logic              prog_we;
    logic              tape_we;
    logic [DATA_W-1:0] tape_wd;
    logic              stk_we;

    logic              load_full;
    logic              step_ok;
    logic [DATA_W-1:0] cell_val;
    logic              cell_new;
    logic [SCW-1:0]    sc_dec;

    // capture the beat
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_mode <= i_mode;
            r_opc  <= t_op'(i_opcode);
            r_inb  <= i_input_byte;
        end
    end

    assign sc_dec = r_sc - SCW'(1);

    // synchronous reads at the current program counter, pointer and stack top
    always_ff @(posedge i_clk) begin
        r_prog_rd <= mem_prog[r_pc[PAW-1:0]];
        r_tape_rd <= mem_tape[r_ptr];
        r_stk_rd  <= mem_stk[sc_dec[SAW-1:0]];
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && prog_we) begin
            mem_prog[r_len[PAW-1:0]] <= r_opc;
        end
        if (i_ctrl.fire && tape_we) begin
            mem_tape[r_ptr] <= tape_wd;
        end
        if (i_ctrl.fire && stk_we) begin
            mem_stk[r_sc[SAW-1:0]] <= r_pc[PAW-1:0];
        end
    end

    // execute one load or one step
    always_comb begin
        n_len   = r_len;
        n_pc    = r_pc;
        n_ptr   = r_ptr;
        n_fill  = r_fill;
        n_sc    = r_sc;
        n_skip  = r_skip;
        n_err   = r_err;
        prog_we = 1'b0;
        tape_we = 1'b0;
        tape_wd = '0;
        stk_we  = 1'b0;

        o_res.out_valid  = 1'b0;
        o_res.out_byte   = '0;
        o_res.took_input = 1'b0;

        load_full = (r_len == PCW'(PROG_DEPTH));
        step_ok   = (r_err == ERR_NONE) && (r_pc < r_len);
        // cells at or above the fill mark were never written and read as zero
        cell_new  = (TFW'(r_ptr) == r_fill);
        cell_val  = (TFW'(r_ptr) < r_fill) ? r_tape_rd : '0;

        if (r_mode == MODE_LOAD) begin
            if (!load_full) begin
                prog_we = 1'b1;
                n_len   = r_len + PCW'(1);
            end
        end else if (step_ok) begin
            if (r_skip != '0) begin
                // scanning for the matching close
                if (r_prog_rd == OP_OPEN) begin
                    n_skip = r_skip + PCW'(1);
                end else if (r_prog_rd == OP_CLOSE) begin
                    n_skip = r_skip - PCW'(1);
                end
                n_pc = r_pc + PCW'(1);
            end else begin
                unique case (r_prog_rd)
                    OP_INC: begin
                        tape_we = 1'b1;
                        tape_wd = cell_val + DATA_W'(1);
                        n_pc    = r_pc + PCW'(1);
                    end
                    OP_DEC: begin
                        tape_we = 1'b1;
                        tape_wd = cell_val - DATA_W'(1);
                        n_pc    = r_pc + PCW'(1);
                    end
                    OP_RIGHT: begin
                        if (r_ptr == TPW'(TAPE_DEPTH - 1)) begin
                            n_err = ERR_PTR_HIGH;
                        end else begin
                            // zero the cell left behind if it was never written
                            tape_we = cell_new;
                            n_ptr   = r_ptr + TPW'(1);
                            n_pc    = r_pc + PCW'(1);
                        end
                    end
                    OP_LEFT: begin
                        if (r_ptr == '0) begin
                            n_err = ERR_PTR_LOW;
                        end else begin
                            n_ptr = r_ptr - TPW'(1);
                            n_pc  = r_pc + PCW'(1);
                        end
                    end
                    OP_OUT: begin
                        o_res.out_valid = 1'b1;
                        o_res.out_byte  = cell_val;
                        n_pc            = r_pc + PCW'(1);
                    end
                    OP_IN: begin
                        tape_we          = 1'b1;
                        tape_wd          = r_inb;
                        o_res.took_input = 1'b1;
                        n_pc             = r_pc + PCW'(1);
                    end
                    OP_OPEN: begin
                        if (cell_val == '0) begin
                            n_skip = PCW'(1);
                            n_pc   = r_pc + PCW'(1);
                        end else if (r_sc == SCW'(LOOP_DEPTH)) begin
                            n_err = ERR_OVERFLOW;
                        end else begin
                            stk_we = 1'b1;
                            n_sc   = r_sc + SCW'(1);
                            n_pc   = r_pc + PCW'(1);
                        end
                    end
                    OP_CLOSE: begin
                        if (r_sc == '0) begin
                            n_err = ERR_UNMATCHED;
                        end else if (cell_val != '0) begin
                            n_pc = PCW'(r_stk_rd) + PCW'(1);
                        end else begin
                            n_sc = sc_dec;
                            n_pc = r_pc + PCW'(1);
                        end
                    end
                endcase
            end
        end

        // every write at the fill mark extends it
        if (tape_we && cell_new) begin
            n_fill = r_fill + TFW'(1);
        end

        o_res.halted          = (n_err != ERR_NONE) || (n_pc >= n_len);
        o_res.error_code      = (r_mode == MODE_LOAD && load_full) ? ERR_PROG_FULL : n_err;
        o_res.program_counter = PCO_W'(n_pc);
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_pc   <= '0;
            r_ptr  <= '0;
            r_fill <= '0;
            r_sc   <= '0;
            r_skip <= '0;
            r_err  <= ERR_NONE;
        end else if (i_ctrl.fire) begin
            r_len  <= n_len;
            r_pc   <= n_pc;
            r_ptr  <= n_ptr;
            r_fill <= n_fill;
            r_sc   <= n_sc;
            r_skip <= n_skip;
            r_err  <= n_err;
        end
    end

endmodule

// ===== rtl/core/tape_machine_interpreter.sv =====
// top level of the tape machine interpreter: stream ports and output register
`timescale 1ns / 1ps

// Eight-instruction tape machine. An input beat with tuser 0 appends its opcode
// to the program store; a beat with tuser 1 carries out one instruction (or one
// scan step of a skipped loop body). Every input beat yields exactly one output
// beat. In the accept cycle the program, tape and loop stack memories are read
// at the current program counter, cell pointer and stack top; the micro-coded
// sequencer then moves to its execute state, where it fires the execute step,
// which writes back state and loads the output register. The execute step waits
// while the output register is still full and not being taken. The tape reads
// as all zero after reset with no clearing pass: a fill mark follows the
// highest cell ever written, and cells at or above it read as zero.

module tape_machine_interpreter
    import tmi_pkg::*;
#(
    parameter int PROG_DEPTH = TMI_PROG_DEPTH,
    parameter int TAPE_DEPTH = TMI_TAPE_DEPTH,
    parameter int LOOP_DEPTH = TMI_LOOP_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [2:0] opcode, [10:3] input_byte, rest zero
    input  logic        i_s_tuser,   // [0] mode
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_byte, [8] took_input, [9] halted,
                                     // [12:10] error_code, [23:13] program_counter
    output logic        o_m_tuser    // [0] out_valid
);

    t_stat stat;
    t_ctrl ctrl;
    t_res  res;
    t_res  r_res;
    logic  r_ov;

    // sequencer
    tmi_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // datapath
    tmi_datapath #(
        .PROG_DEPTH (PROG_DEPTH),
        .TAPE_DEPTH (TAPE_DEPTH),
        .LOOP_DEPTH (LOOP_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_mode       (i_s_tuser),
        .i_opcode     (i_s_tdata[2:0]),
        .i_input_byte (i_s_tdata[10:3]),
        .o_res        (res)
    );

    // status to the sequencer, no beat taken while in reset
    assign stat.in_valid = i_s_tvalid;
    assign stat.out_busy = r_ov && !i_m_tready;
    assign o_s_tready    = ctrl.accept && i_rst_n;

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ctrl.fire) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (ctrl.fire) begin
            r_res <= res;
        end
    end

    // output beat packing
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_res.out_valid;
    assign o_m_tdata  = {r_res.program_counter, r_res.error_code, r_res.halted,
                         r_res.took_input, r_res.out_byte};

endmodule

// ===== bench/tape_machine_interpreter_test.sv =====
// self-checking stream testbench for the tape machine interpreter
`timescale 1ns / 1ps

module tape_machine_interpreter_test;
    import tmi_pkg::*;

    localparam logic MODE_STEP   = ~MODE_LOAD;
    localparam int   HOLD_CYCLES = 150;
    localparam int   LIMIT_NS    = 2_000_000;

    // program model, tape model and queue of results still awaited from the block
    class tmi_scoreboard;
        t_op         prog_mem [TMI_PROG_DEPTH];
        logic [7:0]  tape [TMI_TAPE_DEPTH];
        int          ret_stack [TMI_LOOP_DEPTH];
        int          prog_len;
        int          pc;
        int          ptr;
        int          stack_cnt;
        int          skip_depth;
        logic [2:0]  err;
        t_res        awaited_results [$];
        int          checked;
        int          mismatches;

        function new();
            foreach (tape[k]) tape[k] = 8'd0;
            prog_len   = 0;
            pc         = 0;
            ptr        = 0;
            stack_cnt  = 0;
            skip_depth = 0;
            err        = ERR_NONE;
            checked    = 0;
            mismatches = 0;
        endfunction

        function bit halted_now();
            return (err != ERR_NONE) || (pc >= prog_len);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // advance the machine by one accepted input beat and queue its result
        function void note_item(logic mode, t_op opc, logic [7:0] in_byte);
            t_res       r;
            t_op        op;
            logic [7:0] cell_val;
            bit         full;
            bit         advance;
            r       = '0;
            full    = 1'b0;
            advance = 1'b1;
            if (mode == MODE_LOAD) begin
                if (prog_len < TMI_PROG_DEPTH) begin
                    prog_mem[prog_len] = opc;
                    prog_len++;
                end else begin
                    full = 1'b1;
                end
            end else if (err == ERR_NONE && pc < prog_len) begin
                op       = prog_mem[pc];
                cell_val = tape[ptr];
                if (skip_depth > 0) begin
                    // scanning a skipped loop body
                    if (op == OP_OPEN) skip_depth++;
                    else if (op == OP_CLOSE) skip_depth--;
                end else begin
                    case (op)
                        OP_INC: tape[ptr] = cell_val + 8'd1;
                        OP_DEC: tape[ptr] = cell_val - 8'd1;
                        OP_RIGHT: begin
                            if (ptr + 1 >= TMI_TAPE_DEPTH) begin
                                err     = ERR_PTR_HIGH;
                                advance = 1'b0;
                            end else begin
                                ptr++;
                            end
                        end
                        OP_LEFT: begin
                            if (ptr == 0) begin
                                err     = ERR_PTR_LOW;
                                advance = 1'b0;
                            end else begin
                                ptr--;
                            end
                        end
                        OP_OUT: begin
                            r.out_valid = 1'b1;
                            r.out_byte  = cell_val;
                        end
                        OP_IN: begin
                            tape[ptr]    = in_byte;
                            r.took_input = 1'b1;
                        end
                        OP_OPEN: begin
                            if (cell_val == 8'd0) begin
                                skip_depth = 1;
                            end else if (stack_cnt >= TMI_LOOP_DEPTH) begin
                                err     = ERR_OVERFLOW;
                                advance = 1'b0;
                            end else begin
                                ret_stack[stack_cnt] = pc;
                                stack_cnt++;
                            end
                        end
                        default: begin
                            if (stack_cnt == 0) begin
                                err     = ERR_UNMATCHED;
                                advance = 1'b0;
                            end else if (cell_val != 8'd0) begin
                                // jump back just past the matching open
                                pc      = ret_stack[stack_cnt - 1] + 1;
                                advance = 1'b0;
                            end else begin
                                stack_cnt--;
                            end
                        end
                    endcase
                end
                if (advance) pc++;
            end
            r.error_code      = full ? ERR_PROG_FULL : err;
            r.halted          = halted_now();
            r.program_counter = PCO_W'(pc);
            awaited_results   = {awaited_results, r};
        endfunction

        task report(string field, int unsigned got_v, int unsigned exp_v);
            mismatches++;
            $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                     field, checked, got_v, exp_v);
        endtask

        // compare one output beat with the oldest awaited result
        task check_result(t_res got);
            t_res exp_r;
            if (awaited_results.size() == 0) begin
                report("unexpected beat", 32'(got), 32'd0);
            end else begin
                exp_r = awaited_results.pop_front();
                if (got.out_valid !== exp_r.out_valid)
                    report("out_valid", 32'(got.out_valid), 32'(exp_r.out_valid));
                if (got.out_byte !== exp_r.out_byte)
                    report("out_byte", 32'(got.out_byte), 32'(exp_r.out_byte));
                if (got.took_input !== exp_r.took_input)
                    report("took_input", 32'(got.took_input), 32'(exp_r.took_input));
                if (got.halted !== exp_r.halted)
                    report("halted", 32'(got.halted), 32'(exp_r.halted));
                if (got.error_code !== exp_r.error_code)
                    report("error_code", 32'(got.error_code), 32'(exp_r.error_code));
                if (got.program_counter !== exp_r.program_counter)
                    report("program_counter", 32'(got.program_counter),
                           32'(exp_r.program_counter));
            end
            checked++;
        endtask
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tuser;

    tmi_scoreboard board;
    t_op           prog_q [$];
    int            items_sent = 0;

    tape_machine_interpreter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [2:0] opcode, [10:3] input_byte
        .i_s_tuser  (s_tuser),    // [0] mode
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [7:0] out_byte, [8] took_input, [9] halted,
                                  // [12:10] error_code, [23:13] program_counter
        .o_m_tuser  (m_tuser)     // [0] out_valid
    );

    always #1 i_clk = ~i_clk;

    // idle cycles before the next beat, with calm stretches of no idling
    function automatic int pick_gap(int count, int period);
        return ((count / period) % 4 == 3) ? 0 : $urandom_range(0, 5);
    endfunction

    // mostly small bytes so loops fed by input stay short
    function automatic logic [7:0] rand_byte();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 7));
    endfunction

    // append one opcode to the fragment being built
    function automatic void add_op(t_op op);
        prog_q = {prog_q, op};
    endfunction

    // balanced program fragment: pointer returns to its start, loops always end
    function automatic void gen_frag(int lvl, bit in_loop);
        int count;
        int pick;
        count = $urandom_range(1, 3);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 9);
            // inside a loop body the loop cell is left alone
            if (in_loop) pick = ($urandom_range(0, 1) == 0) ? 3 : 6;
            case (pick)
                // no lone decrement, so a cell never wraps to a long loop count
                0, 1, 2: add_op(OP_INC);
                3, 4: add_op(OP_OUT);
                5: add_op(OP_IN);
                6, 7: begin
                    if (lvl < 3) begin
                        add_op(OP_RIGHT);
                        gen_frag(lvl + 1, 1'b0);
                        add_op(OP_LEFT);
                    end else begin
                        add_op(OP_OUT);
                    end
                end
                default: begin
                    if (lvl < 3) begin
                        add_op(OP_OPEN);
                        gen_frag(lvl + 1, 1'b1);
                        add_op(OP_DEC);
                        add_op(OP_CLOSE);
                    end else begin
                        add_op(OP_INC);
                    end
                end
            endcase
        end
    endfunction

    // offer one input beat and wait for it to be taken
    task automatic send_item(logic mode, t_op opc, logic [7:0] data);
        int gap;
        gap = pick_gap(items_sent, 64);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'd0, data, opc};
        do @(posedge i_clk); while (!s_tready);
        board.note_item(mode, opc, data);
        items_sent++;
    endtask

    task automatic send_step(logic [7:0] data);
        send_item(MODE_STEP, t_op'($urandom_range(0, 7)), data);
    endtask

    task automatic send_load(t_op opc);
        send_item(MODE_LOAD, opc, 8'($urandom_range(0, 255)));
    endtask

    // step until the machine stops or the budget runs out
    task automatic run_steps(int cap, bit intro);
        int n;
        n = 0;
        while (!board.halted_now() && n < cap) begin
            send_step(intro ? 8'd2 : rand_byte());
            n++;
        end
    endtask

    // load the queued fragment, with stray steps mixed in
    task automatic load_queue(int noise);
        foreach (prog_q[k]) begin
            if (noise != 0 && $urandom_range(0, noise) == 0) send_step(rand_byte());
            send_load(prog_q[k]);
        end
        prog_q.delete();
    endtask

    // result side: random stalls, plus long holds so the block backs up
    initial begin : result_sink
        t_res got;
        int   gap;
        int   taken;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = (taken == 250 || taken == 1200) ? HOLD_CYCLES : pick_gap(taken, 48);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            got.out_valid       = m_tuser;
            got.out_byte        = m_tdata[7:0];
            got.took_input      = m_tdata[8];
            got.halted          = m_tdata[9];
            got.error_code      = m_tdata[12:10];
            got.program_counter = m_tdata[23:13];
            board.check_result(got);
            taken++;
        end
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial begin
        logic [2:0] kind;
        t_op        intro_prog [13];
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wrap both ways, output, input, a two-pass loop, a nested skip, moves
        intro_prog = '{OP_DEC, OP_OUT, OP_INC, OP_IN, OP_OPEN, OP_DEC, OP_CLOSE,
                       OP_OPEN, OP_OPEN, OP_CLOSE, OP_CLOSE, OP_RIGHT, OP_LEFT};
        send_step(8'd2);
        foreach (intro_prog[k]) add_op(intro_prog[k]);
        load_queue(0);
        run_steps(40, 1'b1);
        send_step(8'd2);

        // random well-formed programs, loaded in pieces and run
        while (items_sent < 1000) begin
            for (int k = $urandom_range(1, 3); k > 0; k--) gen_frag(0, 1'b0);
            if (board.prog_len + prog_q.size() > TMI_PROG_DEPTH - 40) begin
                prog_q.delete();
                break;
            end
            load_queue(7);
            run_steps(250, 1'b0);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) send_step(rand_byte());
            end
        end
        run_steps(400, 1'b0);

        // end on one latched error, chosen at random
        kind = 3'($urandom_range(ERR_PTR_LOW, ERR_UNMATCHED));
        case (kind)
            ERR_PTR_LOW: add_op(OP_LEFT);
            ERR_PTR_HIGH: begin
                // set the cell from input, then stride right until the tape runs out
                add_op(OP_IN);
                add_op(OP_OPEN);
                repeat (16) add_op(OP_RIGHT);
                add_op(OP_IN);
                add_op(OP_CLOSE);
            end
            ERR_OVERFLOW: begin
                add_op(OP_IN);
                repeat (TMI_LOOP_DEPTH + 1) add_op(OP_OPEN);
            end
            default: add_op(OP_CLOSE);
        endcase
        load_queue(0);
        run_steps(1400, 1'b1);
        repeat (3) send_step(rand_byte());

        // fill the program store, then loads past its end
        while (board.prog_len < TMI_PROG_DEPTH) begin
            if ($urandom_range(0, 7) == 0) send_step(rand_byte());
            send_load(t_op'($urandom_range(0, 7)));
        end
        repeat (3) send_load(t_op'($urandom_range(0, 7)));
        repeat (2) send_step(rand_byte());
        s_tvalid <= 1'b0;

        // drain
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
